/* rtl/core/cec_pkg.sv */
// Shared types and constants for the clique extension checker.
package cec_pkg;

  localparam int VTX_W    = 6;
  localparam int ROW_W    = 64;
  localparam int CNT_W    = 13;
  localparam int ENTRY_W  = 25;
  localparam int FUNC_W   = 2;
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 32;

  // Result beat layout, lowest bit first.
  localparam int OUT_FULL_BIT = 0;
  localparam int OUT_FREE_BIT = 1;
  localparam int OUT_HIT_LSB  = 2;
  localparam int OUT_CNT_LSB  = OUT_HIT_LSB + CNT_W;
  localparam int RES_W        = OUT_CNT_LSB + CNT_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEST   = 2'd2
  } func_t;

  // One stored clique: v0 in the lowest bits, color on top.
  typedef struct packed {
    logic             color;
    logic [VTX_W-1:0] v3;
    logic [VTX_W-1:0] v2;
    logic [VTX_W-1:0] v1;
    logic [VTX_W-1:0] v0;
  } clique_t;

  typedef struct packed {
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] first_hit;
    logic             clique_free;
    logic             table_full;
  } res_t;

endpackage

/* rtl/core/cec_ram.sv */
// Generic single-port-write, registered-read RAM.
module cec_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/clique_extension_checker.sv */
// Top level: monochromatic 4-clique table with candidate row test.
//
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: func; s_tdata: clique fields, candidate_row
// m        out  m_tvalid/m_tready  m_tdata: table_full, clique_free, first_hit, entry_count
//
// Clear, append, the unused code and a test on an empty table build the result on acceptance
// and go to PUT, which loads the output register once it is free.
// A test reads the clique RAM one entry per cycle in SCAN and stops at the first match
// or at the last stored entry; the registered RAM read port sets this pace.
// One item is in flight at a time; the input is taken again once the result is loaded,
// while the output register may still hold the previous beat.
// Reset clears the count and control state; RAM contents need no clearing.
module clique_extension_checker #(
  parameter int MAX_CLIQUES  = 4096,
  parameter int NUM_VERTICES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [5:0] vertex_0, [11:6] vertex_1, [17:12] vertex_2, [23:18] vertex_3,
  // [24] clique_color, [88:25] candidate_row, [95:89] zero
  input  logic [cec_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [cec_pkg::FUNC_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] table_full, [1] clique_free, [14:2] first_hit, [27:15] entry_count, [31:28] zero
  output logic [cec_pkg::M_DATA_W-1:0]  m_tdata
);

  localparam int CW = $clog2(MAX_CLIQUES + 1);
  localparam int AW = (MAX_CLIQUES > 1) ? $clog2(MAX_CLIQUES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLIQUES);
  localparam logic [cec_pkg::ROW_W-1:0] ROW_MASK = (NUM_VERTICES >= cec_pkg::ROW_W) ?
      {cec_pkg::ROW_W{1'b1}} :
      ((cec_pkg::ROW_W'(1) << NUM_VERTICES) - cec_pkg::ROW_W'(1));

  typedef enum logic [1:0] {IDLE, SCAN, PUT} state_t;

  state_t                       state;
  logic [CW-1:0]                count;
  logic [CW-1:0]                scan_addr;
  logic [CW-1:0]                chk_idx;
  logic [cec_pkg::ROW_W-1:0]    row;
  cec_pkg::res_t                res;

  logic                         accept;
  cec_pkg::func_t               func;
  cec_pkg::clique_t             in_clique;
  logic [cec_pkg::ROW_W-1:0]    row_in;
  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [cec_pkg::ENTRY_W-1:0]  ram_rdata;
  cec_pkg::clique_t             ent;
  logic                         match;
  logic                         last;

  function automatic logic [cec_pkg::CNT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [CW+cec_pkg::CNT_W-1:0] w;
    w = {{cec_pkg::CNT_W{1'b0}}, v};
    return w[cec_pkg::CNT_W-1:0];
  endfunction

  assign s_tready  = (state == IDLE);
  assign accept    = s_tvalid && s_tready;
  assign func      = cec_pkg::func_t'(s_tuser);
  assign in_clique = s_tdata[cec_pkg::ENTRY_W-1:0];
  assign row_in    = s_tdata[cec_pkg::ENTRY_W +: cec_pkg::ROW_W];

  assign ram_we    = accept && (func == cec_pkg::FUNC_APPEND) && (count != MAX_CNT);
  assign ram_re    = (accept && (func == cec_pkg::FUNC_TEST)) || (state == SCAN);
  // Start the scan at entry 0 on acceptance, then follow scan_addr.
  assign ram_raddr = (state == SCAN) ? scan_addr[AW-1:0] : '0;

  cec_ram #(
    .WIDTH(cec_pkg::ENTRY_W),
    .DEPTH(MAX_CLIQUES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(in_clique),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ent   = ram_rdata;
  assign match = (row[ent.v0] == ent.color) && (row[ent.v1] == ent.color) &&
                 (row[ent.v2] == ent.color) && (row[ent.v3] == ent.color);
  assign last  = (chk_idx == count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load the output register from PUT when it is free, else drop a taken beat
      if (state == PUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{(cec_pkg::M_DATA_W - cec_pkg::RES_W){1'b0}}, res};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= PUT;
            case (func)
              cec_pkg::FUNC_CLEAR: begin
                count <= '0;
                res   <= '0;
              end
              cec_pkg::FUNC_APPEND: begin
                if (count == MAX_CNT) begin
                  res <= '{entry_count: to_out(count), first_hit: to_out(count),
                           clique_free: 1'b0, table_full: 1'b1};
                end else begin
                  count <= count + 1'b1;
                  res   <= '{entry_count: to_out(count + 1'b1),
                             first_hit: to_out(count + 1'b1),
                             clique_free: 1'b0, table_full: 1'b0};
                end
              end
              cec_pkg::FUNC_TEST: begin
                if (count == '0) begin
                  res <= '{entry_count: '0, first_hit: '0,
                           clique_free: 1'b1, table_full: 1'b0};
                end else begin
                  row       <= row_in & ROW_MASK;
                  chk_idx   <= '0;
                  scan_addr <= CW'(1);
                  state     <= SCAN;
                end
              end
              default: begin
                res <= '{entry_count: to_out(count), first_hit: to_out(count),
                         clique_free: 1'b0, table_full: 1'b0};
              end
            endcase
          end
        end
        SCAN: begin
          // ram_rdata holds entry chk_idx; the next entry is being read
          if (match) begin
            res   <= '{entry_count: to_out(count), first_hit: to_out(chk_idx),
                       clique_free: 1'b0, table_full: 1'b0};
            state <= PUT;
          end else if (last) begin
            res   <= '{entry_count: to_out(count), first_hit: to_out(count),
                       clique_free: 1'b1, table_full: 1'b0};
            state <= PUT;
          end else begin
            chk_idx   <= scan_addr;
            scan_addr <= scan_addr + 1'b1;
          end
        end
        PUT: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/cec_checker.sv */
// Port-level assertions for the clique extension checker, bound to the top level.
module cec_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [cec_pkg::M_DATA_W-1:0] m_tdata
);

  logic                      out_full;
  logic                      out_free;
  logic [cec_pkg::CNT_W-1:0] out_hit;
  logic [cec_pkg::CNT_W-1:0] out_cnt;

  assign out_full = m_tdata[cec_pkg::OUT_FULL_BIT];
  assign out_free = m_tdata[cec_pkg::OUT_FREE_BIT];
  assign out_hit  = m_tdata[cec_pkg::OUT_HIT_LSB +: cec_pkg::CNT_W];
  assign out_cnt  = m_tdata[cec_pkg::OUT_CNT_LSB +: cec_pkg::CNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is still in flight");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_full && out_free))
    else $error("full and free flagged on the same beat");

  a_free_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_free |-> out_hit == out_cnt)
    else $error("free result with hit index other than the count");

  a_full_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_full |-> out_hit == out_cnt)
    else $error("dropped append with hit index other than the count");

endmodule

bind clique_extension_checker cec_checker u_cec_checker (.*);

/* bench/cec_result_checker.sv */
// Result checker for the clique table: predicts each beat's response and compares it.
`timescale 1ns / 100ps

module cec_result_checker
  import cec_pkg::*;
#(
  parameter int MAX_CLIQUES  = 4096,
  parameter int NUM_VERTICES = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // [5:0] vertex_0, [11:6] vertex_1, [17:12] vertex_2, [23:18] vertex_3,
  // [24] clique_color, [88:25] candidate_row, [95:89] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]   s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // [0] table_full, [1] clique_free, [14:2] first_hit, [27:15] entry_count, [31:28] zero
  input  logic [M_DATA_W-1:0] m_tdata,
  output int                  mismatches,
  output int                  results_due
);

  clique_t     held_cliques [MAX_CLIQUES];
  int unsigned held;
  res_t        awaited_results [$];

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Apply one input beat to the shadow table and return the response it must produce.
  function automatic res_t table_response(input logic [FUNC_W-1:0] code,
                                          input logic [S_DATA_W-1:0] beat);
    res_t             r;
    clique_t          c;
    logic [ROW_W-1:0] row;
    logic [VTX_W-1:0] verts [4];
    int unsigned      i;
    bit               found;
    logic             row_bit;
    r = '0;
    case (code)
      FUNC_CLEAR: begin
        held = 0;
      end
      FUNC_APPEND: begin
        if (held >= MAX_CLIQUES) begin
          r.table_full = 1'b1;
        end else begin
          held_cliques[held] = clique_t'(beat[ENTRY_W-1:0]);
          held++;
        end
        r.first_hit = CNT_W'(held);
      end
      FUNC_TEST: begin
        row = beat[ENTRY_W +: ROW_W];
        i = 0;
        found = 1'b0;
        // Walk the table in order and stop on the first monochrome clique.
        while (i < held && !found) begin
          c = held_cliques[i];
          verts = '{c.v0, c.v1, c.v2, c.v3};
          found = 1'b1;
          foreach (verts[k]) begin
            // Vertices past the graph size see a zero row bit.
            row_bit = (verts[k] < NUM_VERTICES) ? row[verts[k]] : 1'b0;
            if (row_bit != c.color) found = 1'b0;
          end
          if (!found) i++;
        end
        r.clique_free = (i >= held);
        r.first_hit   = CNT_W'(i);
      end
      default: begin
        r.first_hit = CNT_W'(held);
      end
    endcase
    r.entry_count = CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      held = 0;
      awaited_results.delete();
    end else begin
      // Output beats always belong to earlier input beats, so retire before adding.
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[RES_W-1:0]);
        if (awaited_results.size() == 0) begin
          report($sformatf("result beat with nothing pending (tdata %h)", m_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (got.table_full !== want.table_full)
            report($sformatf("table_full got %0d expected %0d",
                             got.table_full, want.table_full));
          if (got.clique_free !== want.clique_free)
            report($sformatf("clique_free got %0d expected %0d",
                             got.clique_free, want.clique_free));
          if (got.first_hit !== want.first_hit)
            report($sformatf("first_hit got %0d expected %0d",
                             got.first_hit, want.first_hit));
          if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count got %0d expected %0d",
                             got.entry_count, want.entry_count));
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(table_response(s_tuser, s_tdata));
    end
    results_due <= awaited_results.size();
  end

endmodule

/* bench/testbench.sv */
// Bench top for the clique table: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import cec_pkg::*;

  localparam int MAX_CLIQUES    = 4096;
  localparam int NUM_VERTICES   = 64;
  localparam int RANDOM_ITEMS   = 120;
  localparam int CALM_ITEMS     = 30;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  int mismatches;
  int results_due;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  clique_extension_checker #(
    .MAX_CLIQUES (MAX_CLIQUES),
    .NUM_VERTICES(NUM_VERTICES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  cec_result_checker #(
    .MAX_CLIQUES (MAX_CLIQUES),
    .NUM_VERTICES(NUM_VERTICES)
  ) results_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  function automatic logic [VTX_W-1:0] rv();
    return VTX_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [ROW_W-1:0] rrow();
    return {$urandom, $urandom};
  endfunction

  // Offer one beat, maybe after an idle burst, and hold it until accepted.
  task automatic push_item(input logic [FUNC_W-1:0] code,
                           input logic [VTX_W-1:0] a, b, c, d,
                           input logic col, input logic [ROW_W-1:0] row);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= {7'b0, row, col, d, c, b, a};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every pending result.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [VTX_W-1:0] recent_v [4];
    logic [VTX_W-1:0] va [4];
    logic             recent_col;
    logic             col;
    logic [ROW_W-1:0] row;
    int               pick;
    int               pool;

    recent_v   = '{6'd0, 6'd1, 6'd2, 6'd3};
    recent_col = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extreme vertices, both colors, hits at indices 0 to 2, free rows.
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b1, '1);
    push_item(FUNC_UNUSED, rv(), rv(), rv(), rv(), 1'b0, rrow());
    push_item(FUNC_APPEND, 6'd0, 6'd1, 6'd2, 6'd3, 1'b1, rrow());
    push_item(FUNC_APPEND, 6'd60, 6'd61, 6'd62, 6'd63, 1'b0, rrow());
    push_item(FUNC_APPEND, 6'd63, 6'd63, 6'd63, 6'd63, 1'b1, rrow());
    push_item(FUNC_APPEND, 6'd10, 6'd20, 6'd30, 6'd40, 1'b0, rrow());
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b0, '1);
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b1, '0);
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b0, 64'hF000_0000_0000_0000);
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b1, 64'h7000_0000_0000_0405);
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b1, 64'h5555_5555_5555_5555);
    push_item(FUNC_UNUSED, rv(), rv(), rv(), rv(), 1'b1, rrow());
    push_item(FUNC_CLEAR, rv(), rv(), rv(), rv(), 1'b1, rrow());
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b0, rrow());
    push_item(FUNC_APPEND, 6'd63, 6'd0, 6'd63, 6'd0, 1'b0, rrow());
    push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'b1, 64'h7FFF_FFFF_FFFF_FFFE);
    drain();

    // Random mix on small tables, with rows often steered onto a recent clique.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - CALM_ITEMS);
      if (n == 50) hold_req = 1'b1;
      if (n == 80) drain();
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        push_item(FUNC_CLEAR, rv(), rv(), rv(), rv(), 1'($urandom_range(0, 1)), rrow());
      end else if (pick < 10) begin
        push_item(FUNC_UNUSED, rv(), rv(), rv(), rv(), 1'($urandom_range(0, 1)), rrow());
      end else if (pick < 50) begin
        // A narrow vertex pool makes cliques share vertices.
        pool = ($urandom_range(0, 2) == 0) ? 7 : 63;
        foreach (va[k]) va[k] = VTX_W'($urandom_range(0, pool));
        col = 1'($urandom_range(0, 1));
        push_item(FUNC_APPEND, va[0], va[1], va[2], va[3], col, rrow());
        recent_v   = va;
        recent_col = col;
      end else begin
        case ($urandom_range(0, 4))
          0: row = rrow();
          1: row = rrow() & rrow() & rrow();
          2: row = rrow() | rrow() | rrow();
          3: row = ($urandom_range(0, 1) == 1) ? '1 : '0;
          default: begin
            row = rrow();
            foreach (recent_v[k]) row[recent_v[k]] = recent_col;
          end
        endcase
        push_item(FUNC_TEST, rv(), rv(), rv(), rv(), 1'($urandom_range(0, 1)), row);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* clique_extension_checker.f */
rtl/core/cec_pkg.sv
rtl/core/cec_ram.sv
rtl/core/clique_extension_checker.sv
rtl/core/cec_checker.sv
bench/cec_result_checker.sv
bench/testbench.sv
